// ===== rtl/wbmp_pkg.sv =====
// shared types and constants for the wbmp header checker
package wbmp_pkg;

  localparam int DIM_BITS = 16;
  localparam int GRP_BITS = 7;

  localparam logic [7:0] FIXED_MASK = 8'h9F;

  typedef enum logic [2:0] {
    PH_TYPE,
    PH_FIXED,
    PH_WIDTH,
    PH_HEIGHT,
    PH_DRAIN
  } wbmp_phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } wbmp_in_t;

  typedef struct packed {
    logic                verdict;
    logic [DIM_BITS-1:0] width;
    logic [DIM_BITS-1:0] height;
  } wbmp_out_t;

endpackage

// ===== rtl/wbmp_header_checker.sv =====
// wbmp type 0 header checker: input register, byte decode and result register
//
// Accepts one header byte per cycle, each with a last flag, and emits one
// verdict per header with the decoded width and height (both 0 on failure).
// A byte is captured in the input register and decoded from there into the
// result register once the result side can advance. A new byte is accepted
// every cycle while the result register is empty or being taken; out_stall
// only holds the input side while a verdict waits and another byte is ready
// to advance. After a verdict on a byte without the last flag, the bytes up
// to and including the next last-flagged one are dropped without result; a
// header that runs out of bytes fails.
module wbmp_header_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  wbmp_pkg::wbmp_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output wbmp_pkg::wbmp_out_t out_data
);
  import wbmp_pkg::*;

  logic                in_valid_r;
  wbmp_in_t            in_item_r;
  wbmp_phase_t         phase_r, phase_nxt;
  logic [DIM_BITS-1:0] run_r, run_nxt;
  logic [DIM_BITS-1:0] wid_r, wid_nxt;
  logic                out_valid_r, out_valid_nxt;
  wbmp_out_t           out_data_r, res;

  logic                advance;
  logic                fire;
  logic                emit;
  logic                ok;
  logic                fail;
  logic [7:0]          b;
  logic                last;
  logic [DIM_BITS+GRP_BITS-1:0] v_wide;
  logic [DIM_BITS-1:0] v;
  logic                ovf;
  logic                more;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !advance;
  assign fire     = in_valid_r && advance;

  assign b      = in_item_r.data_byte;
  assign last   = in_item_r.last_byte;
  assign v_wide = {run_r, b[GRP_BITS-1:0]};
  // running value never exceeds the max, so only the shifted-out group can overflow
  assign ovf    = |v_wide[DIM_BITS+GRP_BITS-1:DIM_BITS];
  assign v      = v_wide[DIM_BITS-1:0];
  assign more   = b[7];

  always_comb begin
    phase_nxt = phase_r;
    run_nxt   = run_r;
    wid_nxt   = wid_r;
    emit      = 1'b0;
    ok        = 1'b0;
    fail      = 1'b0;
    if (fire) begin
      case (phase_r)
        PH_TYPE: begin
          if (b != 8'd0 || last) begin
            fail = 1'b1;
          end else begin
            phase_nxt = PH_FIXED;
          end
        end
        PH_FIXED: begin
          if ((b & FIXED_MASK) != 8'd0 || last) begin
            fail = 1'b1;
          end else begin
            phase_nxt = PH_WIDTH;
            run_nxt   = '0;
          end
        end
        PH_WIDTH, PH_HEIGHT: begin
          if (ovf) begin
            fail = 1'b1;
          end else if (more) begin
            if (last) begin
              fail = 1'b1;
            end else begin
              run_nxt = v;
            end
          end else if (v == '0) begin
            fail = 1'b1;
          end else if (phase_r == PH_WIDTH) begin
            if (last) begin
              fail = 1'b1;
            end else begin
              wid_nxt   = v;
              run_nxt   = '0;
              phase_nxt = PH_HEIGHT;
            end
          end else begin
            emit      = 1'b1;
            ok        = 1'b1;
            phase_nxt = last ? PH_TYPE : PH_DRAIN;
            run_nxt   = '0;
            wid_nxt   = '0;
          end
        end
        default: begin
          if (last) begin
            phase_nxt = PH_TYPE;
          end
          run_nxt = '0;
          wid_nxt = '0;
        end
      endcase
      if (fail) begin
        emit      = 1'b1;
        phase_nxt = last ? PH_TYPE : PH_DRAIN;
        run_nxt   = '0;
        wid_nxt   = '0;
      end
    end
    res.verdict = ok;
    res.width   = ok ? wid_r : '0;
    res.height  = ok ? v : '0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = fire && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      phase_r     <= PH_TYPE;
      run_r       <= '0;
      wid_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      phase_r     <= phase_nxt;
      run_r       <= run_nxt;
      wid_r       <= wid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_data;
    end
    if (fire && emit) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/wbmp_header_checker_chk.sv =====
// port-level checker for the wbmp header checker and its bind
module wbmp_header_checker_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input wbmp_pkg::wbmp_in_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input wbmp_pkg::wbmp_out_t out_data
);
  import wbmp_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // a waiting verdict holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled verdict changed");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.verdict |-> out_data.width == '0 && out_data.height == '0)
    else $error("failing verdict carries sizes");

  a_pass_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.verdict |-> out_data.width != '0 && out_data.height != '0)
    else $error("passing verdict with zero size");

  // no byte in flight means no new verdict
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !in_acc && !$past(in_acc) |=> !out_valid)
    else $error("verdict without a byte");

endmodule

bind wbmp_header_checker wbmp_header_checker_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
